@@ rtl/prm_pkg.sv @@
// ============================================================================
// prm_pkg: shared types and constants of the pulse rate monitor
// Field widths, register indexes, send reason codes and the status records
// that pass between the serial units and the control logic.
// ============================================================================
package prm_pkg;

    // Field widths fixed by the register map and the result format.
    localparam int TIME_W      = 32;
    localparam int TIME_CNT_W  = 5;
    localparam int GAP_W       = 16;
    localparam int DIV_CNT_W   = 4;
    localparam int RATE_W      = 8;
    localparam int THR_W       = 12;
    localparam int LIMIT_W     = 8;
    localparam int REASON_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int M_TDATA_W   = 16;

    // Rate arithmetic.
    localparam logic [GAP_W-1:0]  RATE_NUMERATOR = 16'd60000;
    localparam logic [RATE_W-1:0] RATE_MAX       = 8'hFF;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BEAT_GAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BEAT_GAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_RATE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL   = 3'd4;

    // Register values after reset.
    localparam logic [THR_W-1:0]   RST_LEVEL_THRESHOLD = 12'd1000;
    localparam logic [GAP_W-1:0]   RST_MIN_BEAT_GAP    = 16'd300;
    localparam logic [GAP_W-1:0]   RST_MAX_BEAT_GAP    = 16'd2000;
    localparam logic [LIMIT_W-1:0] RST_HIGH_RATE_LIMIT = 8'd100;
    localparam logic [TIME_W-1:0]  RST_SEND_INTERVAL   = 32'd10000;

    // Send reason codes.
    localparam logic [REASON_W-1:0] REASON_NONE     = 2'd0;
    localparam logic [REASON_W-1:0] REASON_HIGH     = 2'd1;
    localparam logic [REASON_W-1:0] REASON_PERIODIC = 2'd2;

    // Outcome of the bit-serial time unit, held after its done pulse.
    typedef struct packed {
        logic [GAP_W-1:0] gap;
        logic             gap_in_window;
        logic             elapsed_ge;
        logic             interval_zero;
    } time_result_t;

    // Outcome of the history scan.
    typedef struct packed {
        logic scan_done;
        logic others_high;
    } ring_status_t;

endpackage

@@ rtl/prm_time_serial.sv @@
// ============================================================================
// prm_time_serial: bit-serial time differences and compares
// Shifts the current time and the two stored event times out LSB first,
// forms both 32-bit differences one bit per cycle and compares them on the
// fly against the beat gap window and the send interval.
// ============================================================================
module prm_time_serial (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [prm_pkg::TIME_W-1:0]      now_ms,
    input  logic [prm_pkg::TIME_W-1:0]      last_beat,
    input  logic [prm_pkg::TIME_W-1:0]      last_send,
    input  logic [prm_pkg::GAP_W-1:0]       min_gap,
    input  logic [prm_pkg::GAP_W-1:0]       max_gap,
    input  logic [prm_pkg::TIME_W-1:0]      interval,
    output logic                            done,
    output prm_pkg::time_result_t           result
);
    import prm_pkg::*;

    localparam logic [TIME_CNT_W-1:0] LAST_BIT = TIME_CNT_W'(TIME_W - 1);

    logic [TIME_W-1:0]     now_sr_reg, beat_sr_reg, send_sr_reg, int_sr_reg;
    logic [GAP_W-1:0]      min_sr_reg, max_sr_reg, gap_sr_reg;
    logic                  borrow_g_reg, borrow_e_reg;
    logic                  gt_min_reg, lt_max_reg, ge_int_reg, int_zero_reg;
    logic [TIME_CNT_W-1:0] bit_cnt_reg;
    logic                  busy_reg, done_reg;

    logic a_bit, b_bit, c_bit, d_gap, d_ela;

    // One bit of each serial subtractor.
    always_comb begin
        a_bit = now_sr_reg[0];
        b_bit = beat_sr_reg[0];
        c_bit = send_sr_reg[0];
        d_gap = a_bit ^ b_bit ^ borrow_g_reg;
        d_ela = a_bit ^ c_bit ^ borrow_e_reg;
    end

    // Payload shift registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            now_sr_reg  <= now_ms;
            beat_sr_reg <= last_beat;
            send_sr_reg <= last_send;
            int_sr_reg  <= interval;
            min_sr_reg  <= min_gap;
            max_sr_reg  <= max_gap;
        end else if (busy_reg) begin
            now_sr_reg  <= {1'b0, now_sr_reg[TIME_W-1:1]};
            beat_sr_reg <= {1'b0, beat_sr_reg[TIME_W-1:1]};
            send_sr_reg <= {1'b0, send_sr_reg[TIME_W-1:1]};
            int_sr_reg  <= {1'b0, int_sr_reg[TIME_W-1:1]};
            min_sr_reg  <= {1'b0, min_sr_reg[GAP_W-1:1]};
            max_sr_reg  <= {1'b0, max_sr_reg[GAP_W-1:1]};
            // Only the low half of the gap is kept for the divider.
            if (bit_cnt_reg < TIME_CNT_W'(GAP_W)) begin
                gap_sr_reg <= {d_gap, gap_sr_reg[GAP_W-1:1]};
            end
        end
    end

    // Borrows and LSB-first compare flags; a higher differing bit overrides.
    always_ff @(posedge aclk) begin
        if (start) begin
            borrow_g_reg <= 1'b0;
            borrow_e_reg <= 1'b0;
            gt_min_reg   <= 1'b0;
            lt_max_reg   <= 1'b0;
            ge_int_reg   <= 1'b1;
            int_zero_reg <= 1'b1;
        end else if (busy_reg) begin
            borrow_g_reg <= (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_g_reg);
            borrow_e_reg <= (~a_bit & c_bit) | (~(a_bit ^ c_bit) & borrow_e_reg);
            if (d_gap != min_sr_reg[0]) begin
                gt_min_reg <= d_gap;
            end
            if (d_gap != max_sr_reg[0]) begin
                lt_max_reg <= max_sr_reg[0];
            end
            if (d_ela != int_sr_reg[0]) begin
                ge_int_reg <= d_ela;
            end
            int_zero_reg <= int_zero_reg & ~int_sr_reg[0];
        end
    end

    // Bit counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
            end else if (busy_reg) begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done                 = done_reg;
    assign result.gap           = gap_sr_reg;
    assign result.gap_in_window = gt_min_reg & lt_max_reg;
    assign result.elapsed_ge    = ge_int_reg;
    assign result.interval_zero = int_zero_reg;

endmodule

@@ rtl/prm_rate_div.sv @@
// ============================================================================
// prm_rate_div: serial rate divider
// Restoring division of the fixed numerator by the beat gap, one quotient
// bit per cycle, with the result saturated to the rate width.
// ============================================================================
module prm_rate_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [prm_pkg::GAP_W-1:0]     divisor,
    output logic                          done,
    output logic [prm_pkg::RATE_W-1:0]    rate
);
    import prm_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(GAP_W - 1);

    logic [GAP_W-1:0]     rem_reg, quo_reg, dvd_reg, dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;

    logic [GAP_W:0]   trial, diff;
    logic             fits;
    logic [GAP_W-1:0] rem_next;

    // One restoring step: bring down the next dividend bit and try to subtract.
    // The partial remainder stays below twice the divisor, so a clear top bit
    // of the difference means there was no borrow and the divisor fits.
    always_comb begin
        trial    = {rem_reg, dvd_reg[GAP_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = ~diff[GAP_W];
        rem_next = fits ? diff[GAP_W-1:0] : trial[GAP_W-1:0];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= '0;
            dvd_reg <= RATE_NUMERATOR;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[GAP_W-2:0], fits};
            dvd_reg <= {dvd_reg[GAP_W-2:0], 1'b0};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Saturate quotients that do not fit the rate field.
    assign rate = (|quo_reg[GAP_W-1:RATE_W]) ? RATE_MAX : quo_reg[RATE_W-1:0];
    assign done = done_reg;

endmodule

@@ rtl/prm_rate_ring.sv @@
// ============================================================================
// prm_rate_ring: ring of recent rates with a serial scan
// Holds the recent rates in a small memory. A scan reads one entry per
// cycle and checks that every entry other than the slot about to be
// overwritten lies above the high limit. Entries are filled in order after
// reset, so a fill flag stands in for clearing the memory.
// ============================================================================
module prm_rate_ring #(
    parameter int DEPTH = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           scan_start,
    input  logic [prm_pkg::LIMIT_W-1:0]    limit,
    input  logic                           commit,
    input  logic [prm_pkg::RATE_W-1:0]     wdata,
    output prm_pkg::ring_status_t          status
);
    import prm_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [RATE_W-1:0] mem [DEPTH];
    logic [RATE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             full_reg, full_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             scanning_reg, scanning_next;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             ok_reg, ok_next;
    logic             done_reg, done_next;
    logic             entry_high;

    // History memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (commit) begin
            mem[slot_reg] <= wdata;
        end
        if (scanning_reg) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    // Scan and slot control.
    always_comb begin
        entry_high    = (rd_data_reg > limit) && (rd_data_reg != '0);
        slot_next     = slot_reg;
        full_next     = full_reg;
        scan_idx_next = scan_idx_reg;
        scanning_next = scanning_reg;
        ok_next       = ok_reg;
        done_next     = rd_vld_reg && (rd_idx_reg == LAST_IDX);

        if (commit) begin
            slot_next = (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
            full_next = full_reg | (slot_reg == LAST_IDX);
        end

        if (scan_start) begin
            scan_idx_next = '0;
            scanning_next = 1'b1;
            ok_next       = 1'b1;
        end else begin
            if (scanning_reg) begin
                if (scan_idx_reg == LAST_IDX) begin
                    scanning_next = 1'b0;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            // The slot about to be written is judged by the new rate instead.
            if (rd_vld_reg && (rd_idx_reg != slot_reg) && !entry_high) begin
                ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            full_reg     <= 1'b0;
            scan_idx_reg <= '0;
            scanning_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            ok_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            slot_reg     <= slot_next;
            full_reg     <= full_next;
            scan_idx_reg <= scan_idx_next;
            scanning_reg <= scanning_next;
            rd_vld_reg   <= scanning_reg;
            rd_idx_reg   <= scan_idx_reg;
            ok_reg       <= ok_next;
            done_reg     <= done_next;
        end
    end

    // The ring is only all high once every entry has been written.
    assign status.scan_done   = done_reg;
    assign status.others_high = ok_reg && (full_reg || (slot_reg == LAST_IDX));

    // A write must never land in the middle of a scan.
    a_no_commit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!scanning_reg && !rd_vld_reg))
        else $error("history write during scan");

endmodule

@@ rtl/pulse_rate_monitor.sv @@
// ============================================================================
// pulse_rate_monitor: beat detection and rate reporting
// Detects rising threshold crossings of a pulse sensor, converts the beat
// gap to beats per minute and flags when the rate should be reported.
// ============================================================================
//
//  Channel  Direction  Payload (LSB first)                     Handshake
//  s_       in         sample, now_ms                          s_tvalid/s_tready
//  m_       out        rate_bpm, beat_seen, send_now, reason   m_tvalid/m_tready
//  cfg_     in         register index, write data              cfg_we only
//
//  One request at a time. The 32-bit bit-serial subtractor and the history
//  scan run side by side; when a beat falls inside the gap window, the
//  serial divider runs after them.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A result waits in the output register while the next request is taken;
//  a stalled output holds only the final write-back of the following one.
//
module pulse_rate_monitor #(
    parameter int HISTORY_DEPTH = 10,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata: sample, now_ms, zero padding.
    input  logic [((SAMPLE_BITS + prm_pkg::TIME_W + 7) / 8) * 8 - 1:0] s_tdata,
    // Result stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata: rate_bpm, beat_seen, send_now, send_reason, zero padding.
    output logic [prm_pkg::M_TDATA_W-1:0]          m_tdata,
    // Configuration writes.
    input  logic                                   cfg_we,
    input  logic [prm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [prm_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
    import prm_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Configuration registers.
    logic [THR_W-1:0]   thr_reg;
    logic [GAP_W-1:0]   min_gap_reg, max_gap_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [TIME_W-1:0]  interval_reg;

    // Control and state.
    logic [1:0]             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] prev_sample_reg, prev_sample_next;
    logic [TIME_W-1:0]      last_beat_reg, last_beat_next;
    logic [TIME_W-1:0]      last_send_reg, last_send_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic                   time_done_reg, time_done_next;
    logic                   scan_done_reg, scan_done_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // Per-request payload.
    logic [TIME_W-1:0]   now_reg;
    logic                beat_reg;
    logic [RATE_W-1:0]   rate_out_reg;
    logic                beat_out_reg, send_now_reg;
    logic [REASON_W-1:0] send_reason_reg;

    logic [SAMPLE_BITS-1:0] s_sample;
    logic [TIME_W-1:0]      s_now;
    logic                   accept, out_free, beat_now;
    logic                   div_start, div_done, commit;
    logic [RATE_W-1:0]      div_rate;
    logic                   time_done;
    time_result_t           time_res;
    ring_status_t           ring_status;
    logic                   all_high, periodic_hit, send_any;

    assign s_sample = s_tdata[SAMPLE_BITS-1:0];
    assign s_now    = s_tdata[SAMPLE_BITS +: TIME_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Rising crossing of the level threshold.
    assign beat_now = (CMP_W'(s_sample) > CMP_W'(thr_reg)) &&
                      (CMP_W'(prev_sample_reg) <= CMP_W'(thr_reg));

    // Send decision; a sustained-high send moves the last send time to now,
    // so the periodic test then only passes with a zero interval.
    assign all_high     = ring_status.others_high && (rate_reg > limit_reg) &&
                          (rate_reg != '0);
    assign periodic_hit = (all_high ? time_res.interval_zero : time_res.elapsed_ge) &&
                          (rate_reg != '0);
    assign send_any     = all_high || periodic_hit;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= RST_LEVEL_THRESHOLD;
            min_gap_reg  <= RST_MIN_BEAT_GAP;
            max_gap_reg  <= RST_MAX_BEAT_GAP;
            limit_reg    <= RST_HIGH_RATE_LIMIT;
            interval_reg <= RST_SEND_INTERVAL;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LEVEL_THRESHOLD: thr_reg      <= cfg_wdata[THR_W-1:0];
                REG_MIN_BEAT_GAP:    min_gap_reg  <= cfg_wdata[GAP_W-1:0];
                REG_MAX_BEAT_GAP:    max_gap_reg  <= cfg_wdata[GAP_W-1:0];
                REG_HIGH_RATE_LIMIT: limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                REG_SEND_INTERVAL:   interval_reg <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: serial time unit and scan, then the divider for an in-window beat, then write-back.
    always_comb begin
        state_next       = state_reg;
        prev_sample_next = prev_sample_reg;
        last_beat_next   = last_beat_reg;
        last_send_next   = last_send_reg;
        rate_next        = rate_reg;
        time_done_next   = time_done_reg | time_done;
        scan_done_next   = scan_done_reg | ring_status.scan_done;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        div_start        = 1'b0;
        commit           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    prev_sample_next = s_sample;
                    time_done_next   = 1'b0;
                    scan_done_next   = 1'b0;
                    state_next       = ST_RUN;
                end
            end
            ST_RUN: begin
                if (time_done_reg && scan_done_reg) begin
                    if (beat_reg && time_res.gap_in_window) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    rate_next  = div_rate;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    commit        = 1'b1;
                    if (beat_reg) begin
                        last_beat_next = now_reg;
                    end
                    if (send_any) begin
                        last_send_next = now_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            prev_sample_reg <= '0;
            last_beat_reg   <= '0;
            last_send_reg   <= '0;
            rate_reg        <= '0;
            time_done_reg   <= 1'b0;
            scan_done_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            prev_sample_reg <= prev_sample_next;
            last_beat_reg   <= last_beat_next;
            last_send_reg   <= last_send_next;
            rate_reg        <= rate_next;
            time_done_reg   <= time_done_next;
            scan_done_reg   <= scan_done_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg  <= s_now;
            beat_reg <= beat_now;
        end
        if (commit) begin
            rate_out_reg    <= rate_reg;
            beat_out_reg    <= beat_reg;
            send_now_reg    <= send_any;
            send_reason_reg <= all_high ? REASON_HIGH :
                               (periodic_hit ? REASON_PERIODIC : REASON_NONE);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - RATE_W - 2 - REASON_W)'(0), send_reason_reg,
                       send_now_reg, beat_out_reg, rate_out_reg};

    prm_time_serial u_time (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .now_ms    (s_now),
        .last_beat (last_beat_reg),
        .last_send (last_send_reg),
        .min_gap   (min_gap_reg),
        .max_gap   (max_gap_reg),
        .interval  (interval_reg),
        .done      (time_done),
        .result    (time_res)
    );

    prm_rate_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (time_res.gap),
        .done    (div_done),
        .rate    (div_rate)
    );

    prm_rate_ring #(
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_start (accept),
        .limit      (limit_reg),
        .commit     (commit),
        .wdata      (rate_reg),
        .status     (ring_status)
    );

    // An accepted request always starts the serial units.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_RUN))
        else $error("accepted request did not start processing");

    // A reason is given exactly when a send is flagged.
    a_reason_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (send_now_reg == (send_reason_reg != REASON_NONE)))
        else $error("send reason inconsistent with send flag");

    // The rate only changes when the divider finishes.
    a_rate_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DIV) |=> $stable(rate_reg))
        else $error("rate changed outside the divide step");

endmodule

@@ verif/pulse_rate_monitor_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pulse_rate_monitor_checker: result predictor and scoreboard
// Watches the sample, result and register-write ports of the pulse rate
// monitor. Each accepted sample is run through a cycle-free copy of the beat
// and send logic. Each accepted result is compared field by field with the
// oldest expected report.
// ============================================================================
module pulse_rate_monitor_checker #(
    parameter int RING_DEPTH = 10,
    parameter int SAMPLE_W   = 12,
    parameter int S_TDATA_W  = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [S_TDATA_W-1:0]                s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [prm_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [prm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output int                                  fail_count,
    output int                                  reports_due
);
    import prm_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0]   rate_bpm;
        logic                beat_seen;
        logic                send_now;
        logic [REASON_W-1:0] send_reason;
    } bpm_report_t;

    // Register copies.
    logic [THR_W-1:0]   cfg_threshold;
    logic [GAP_W-1:0]   cfg_min_gap;
    logic [GAP_W-1:0]   cfg_max_gap;
    logic [LIMIT_W-1:0] cfg_high_limit;
    logic [TIME_W-1:0]  cfg_send_interval;

    // Detector state.
    logic [SAMPLE_W-1:0] prev_level;
    logic [TIME_W-1:0]   beat_stamp;
    logic [TIME_W-1:0]   send_stamp;
    logic [RATE_W-1:0]   rate_now;
    logic [RATE_W-1:0]   rate_ring [RING_DEPTH];
    int                  ring_slot;

    bpm_report_t pending_reports[$];
    int          errors = 0;

    // Work out the report that one sample causes and queue it.
    task automatic predict_report(input logic [SAMPLE_W-1:0] level,
                                  input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] quotient;
        logic              all_high;
        bpm_report_t       rpt;
        rpt.beat_seen   = 1'b0;
        rpt.send_now    = 1'b0;
        rpt.send_reason = REASON_NONE;

        // A rising crossing is a beat; only gaps inside the window set the rate.
        if (level > cfg_threshold && prev_level <= cfg_threshold) begin
            gap = now - beat_stamp;
            rpt.beat_seen = 1'b1;
            if (gap > 32'(cfg_min_gap) && gap < 32'(cfg_max_gap)) begin
                quotient = 32'(RATE_NUMERATOR) / gap;
                rate_now = (quotient > 32'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
            end
            beat_stamp = now;
        end

        rate_ring[ring_slot] = rate_now;
        ring_slot = (ring_slot + 1) % RING_DEPTH;

        // Sustained high rate takes priority over the periodic send.
        all_high = 1'b1;
        for (int k = 0; k < RING_DEPTH; k++) begin
            if (rate_ring[k] <= cfg_high_limit || rate_ring[k] == '0)
                all_high = 1'b0;
        end
        if (all_high) begin
            rpt.send_now    = 1'b1;
            rpt.send_reason = REASON_HIGH;
            send_stamp      = now;
        end
        if (now - send_stamp >= cfg_send_interval && rate_now != '0) begin
            if (!rpt.send_now) begin
                rpt.send_now    = 1'b1;
                rpt.send_reason = REASON_PERIODIC;
            end
            send_stamp = now;
        end

        prev_level   = level;
        rpt.rate_bpm = rate_now;
        pending_reports.push_back(rpt);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        bpm_report_t want;
        if (!aresetn) begin
            cfg_threshold     = RST_LEVEL_THRESHOLD;
            cfg_min_gap       = RST_MIN_BEAT_GAP;
            cfg_max_gap       = RST_MAX_BEAT_GAP;
            cfg_high_limit    = RST_HIGH_RATE_LIMIT;
            cfg_send_interval = RST_SEND_INTERVAL;
            prev_level        = '0;
            beat_stamp        = '0;
            send_stamp        = '0;
            rate_now          = '0;
            ring_slot         = 0;
            for (int k = 0; k < RING_DEPTH; k++) rate_ring[k] = '0;
            pending_reports.delete();
        end else begin
            // Register writes; indexes past the map are dropped.
            if (cfg_we) begin
                case (cfg_index)
                    REG_LEVEL_THRESHOLD: cfg_threshold     = cfg_wdata[THR_W-1:0];
                    REG_MIN_BEAT_GAP:    cfg_min_gap       = cfg_wdata[GAP_W-1:0];
                    REG_MAX_BEAT_GAP:    cfg_max_gap       = cfg_wdata[GAP_W-1:0];
                    REG_HIGH_RATE_LIMIT: cfg_high_limit    = cfg_wdata[LIMIT_W-1:0];
                    REG_SEND_INTERVAL:   cfg_send_interval = cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                predict_report(s_tdata[SAMPLE_W-1:0], s_tdata[SAMPLE_W +: TIME_W]);

            // Compare each delivered report with the oldest expected one.
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("rate_bpm", 32'(want.rate_bpm), 32'(m_tdata[7:0]));
                    check_field("beat_seen", 32'(want.beat_seen), 32'(m_tdata[8]));
                    check_field("send_now", 32'(want.send_now), 32'(m_tdata[9]));
                    check_field("send_reason", 32'(want.send_reason),
                                32'(m_tdata[11:10]));
                    check_field("padding", 32'd0, 32'(m_tdata[M_TDATA_W-1:12]));
                end
            end
        end
        fail_count  <= errors;
        reports_due <= pending_reports.size();
    end

endmodule

@@ verif/pulse_rate_monitor_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pulse_rate_monitor_tb: stimulus and verdict for the pulse rate monitor
// Drives directed samples at the reset settings, then trains of beats with
// random gaps and random noise under several register settings and idle
// patterns, including a long result hold-off. The checker does the scoring.
// ============================================================================
module pulse_rate_monitor_tb;
    import prm_pkg::*;

    localparam int RING_DEPTH  = 10;
    localparam int SAMPLE_W    = 12;
    localparam int S_TDATA_W   = ((SAMPLE_W + TIME_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND_MAP = REG_SEND_INTERVAL + 3'd1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int reports_due;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_count  = 0;
    logic hold_armed = 1'b0;
    int items_sent  = 0;

    // Register values as last written, used to shape the stimulus.
    logic [THR_W-1:0]   thr_set = RST_LEVEL_THRESHOLD;
    logic [GAP_W-1:0]   min_set = RST_MIN_BEAT_GAP;
    logic [GAP_W-1:0]   max_set = RST_MAX_BEAT_GAP;
    logic [LIMIT_W-1:0] lim_set = RST_HIGH_RATE_LIMIT;
    logic [TIME_W-1:0]  beat_ms = '0;

    pulse_rate_monitor #(
        .HISTORY_DEPTH(RING_DEPTH),
        .SAMPLE_BITS  (SAMPLE_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    pulse_rate_monitor_checker #(
        .RING_DEPTH(RING_DEPTH),
        .SAMPLE_W  (SAMPLE_W),
        .S_TDATA_W (S_TDATA_W)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .reports_due(reports_due)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, and one long hold-off once it is armed.
    always @(posedge aclk) begin
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [THR_W-1:0] low_level();
        return THR_W'($urandom_range(0, thr_set));
    endfunction

    function automatic logic [THR_W-1:0] high_level();
        if (thr_set == '1)
            return '1;
        return THR_W'($urandom_range(thr_set + 1, (1 << SAMPLE_W) - 1));
    endfunction

    // Offer one request and wait for it to be taken, then maybe go idle.
    task automatic put_sample(input logic [SAMPLE_W-1:0] level, input logic [TIME_W-1:0] now);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - SAMPLE_W - TIME_W){1'b0}}, now, level};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Hold the input quiet until every expected result has been delivered.
    task automatic wait_reports_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] thr, input logic [31:0] min_gap,
                                 input logic [31:0] max_gap, input logic [31:0] limit,
                                 input logic [31:0] interval);
        write_reg(REG_LEVEL_THRESHOLD, thr);
        write_reg(REG_MIN_BEAT_GAP, min_gap);
        write_reg(REG_MAX_BEAT_GAP, max_gap);
        write_reg(REG_HIGH_RATE_LIMIT, limit);
        write_reg(REG_SEND_INTERVAL, interval);
        cfg_we  <= 1'b0;
        thr_set = thr[THR_W-1:0];
        min_set = min_gap[GAP_W-1:0];
        max_set = max_gap[GAP_W-1:0];
        lim_set = limit[LIMIT_W-1:0];
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 28; stall_pct = 28; end
        endcase
    endtask

    // A run of beats whose gaps follow one regime: inside the gap window,
    // fast enough for the high-rate send, very short, or anywhere.
    task automatic run_train(input int beats);
        logic [31:0] g_lo;
        logic [31:0] g_hi;
        logic [31:0] g;
        int          regime;
        regime = $urandom_range(0, 9);
        if (regime < 5) begin
            g_lo = 32'(min_set);
            g_hi = 32'(max_set);
        end else if (regime < 8) begin
            g_lo = 32'(min_set);
            g_hi = 60000 / (32'(lim_set) + 1);
        end else if (regime == 8) begin
            g_lo = 0;
            g_hi = 240;
        end else begin
            g_lo = 0;
            g_hi = 70000;
        end
        for (int k = 0; k < beats; k++) begin
            case ($urandom_range(0, 7))
                0: g = g_lo;
                1: g = g_hi;
                default: g = $urandom_range(g_lo, g_hi);
            endcase
            if ($urandom_range(0, 1))
                put_sample(high_level(), beat_ms + g / 4);
            put_sample(low_level(), beat_ms + g / 2);
            beat_ms = beat_ms + g;
            put_sample(high_level(), beat_ms);
        end
    endtask

    // Unshaped samples with random time steps, including jumps anywhere.
    task automatic run_noise(input int count);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0: beat_ms = $urandom();
                1: ;
                default: beat_ms = beat_ms + $urandom_range(0, 2000);
            endcase
            put_sample(SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1)), beat_ms);
        end
    endtask

    // Mostly beat trains, some noise; the idle pattern changes every 60 requests.
    task automatic run_random(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            set_idle(((items_sent - start) / 60) % 4);
            if ($urandom_range(0, 3) != 0)
                run_train($urandom_range(4, 14));
            else
                run_noise($urandom_range(1, 6));
        end
        wait_reports_done();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples at the reset settings: gaps below, on and inside
        // the window edges, a sample exactly at the threshold, time wrap,
        // and the extreme field values.
        set_idle(0);
        put_sample(12'd0, 32'd0);
        put_sample(12'hFFF, 32'd100);
        put_sample(12'd1000, 32'd200);
        put_sample(12'd1001, 32'd700);
        put_sample(12'd0, 32'd800);
        put_sample(12'd2000, 32'd1300);
        put_sample(12'd0, 32'd1400);
        put_sample(12'd3000, 32'd1700);
        put_sample(12'd500, 32'd1800);
        put_sample(12'd1500, 32'd2000);
        put_sample(12'd0, 32'd2100);
        put_sample(12'd1500, 32'd4000);
        put_sample(12'd0, 32'd4100);
        put_sample(12'd1500, 32'd5999);
        put_sample(12'd0, 32'hFFFF_FE00);
        put_sample(12'd2000, 32'hFFFF_FF00);
        put_sample(12'd0, 32'hFFFF_FF80);
        put_sample(12'd2000, 32'h0000_0100);
        put_sample(12'd0, 32'hFFFF_FFFF);
        put_sample(12'hFFF, 32'hFFFF_FFFF);
        beat_ms = 32'h0000_0100;
        wait_reports_done();

        // Writes past the register map must change nothing; the write
        // enable stays high straight into the next register load.
        for (int k = 0; k < 3; k++)
            write_reg(CFG_IDX_W'(REG_BEYOND_MAP + k), $urandom());

        // Threshold 2048, widest window bounds, zero limit and interval: saturated
        // rates, zero gaps and both send conditions at once.
        load_settings(32'd2048, 32'd0, 32'd65535, 32'd0, 32'd0);
        run_random(250);

        // Highest threshold, empty window, widest interval.
        load_settings(32'd4095, 32'd65535, 32'd0, 32'd255, 32'hFFFF_FFFF);
        run_random(150);

        // Zero threshold, running close to the time wrap.
        load_settings(32'd0, 32'd250, 32'd1500, 32'd150, 32'd3000);
        beat_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        run_random(250);

        // Long result hold-off while requests keep coming.
        set_idle(0);
        hold_armed <= 1'b1;
        run_train(14);
        wait_reports_done();

        // Back to the reset values.
        load_settings(32'(RST_LEVEL_THRESHOLD), 32'(RST_MIN_BEAT_GAP),
                      32'(RST_MAX_BEAT_GAP), 32'(RST_HIGH_RATE_LIMIT),
                      RST_SEND_INTERVAL);
        run_random(250);

        // Random settings with junk above the width of every register narrower than 32 bits.
        for (int p = 0; p < 2; p++) begin
            load_settings(($urandom() & 32'hFFFF_F000) | $urandom_range(200, 3800),
                          ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 600),
                          ($urandom() & 32'hFFFF_0000) | $urandom_range(400, 5000),
                          ($urandom() & 32'hFFFF_FF00) | $urandom_range(0, 255),
                          $urandom_range(0, 30000));
            run_random(250);
        end

        // Let any stray result show up before the verdict.
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && reports_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/prm_pkg.sv
rtl/prm_time_serial.sv
rtl/prm_rate_div.sv
rtl/prm_rate_ring.sv
rtl/pulse_rate_monitor.sv
verif/pulse_rate_monitor_checker.sv
verif/pulse_rate_monitor_tb.sv
